[src/mme_pkg.sv]
// Shared types and constants for the matrix multiply engine.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package mme_pkg;

    // Store dimensions.
    localparam int MAX_ROWS  = 16;
    localparam int MAX_INNER = 256;
    localparam int MAX_COLS  = 64;

    // Index widths derived from the store dimensions.
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int INNER_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Exact Q25.16 accumulator: one signed product plus growth for the sum.
    localparam int PROD_W = 32;
    localparam int ACC_W  = PROD_W + INNER_W + 1;

    // Result queue that decouples the MAC pipeline from the output handshake.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    // Configuration port.
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_B    = 2'd2;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Identity of one result column as it travels down the MAC pipeline.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_col;
    } tag_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               a_we;
        logic               b_we;
        logic               rd_en;
        logic               first;
        logic               last_k;
        logic [INNER_W-1:0] k;
        tag_t               tag;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop;
    } sts_t;

    // One finished result in the output queue.
    typedef struct packed {
        logic [3:0]         row;
        logic [5:0]         col;
        logic signed [15:0] value;
        logic               sat;
        logic               last;
    } result_t;

endpackage

[src/mme_ctrl.sv]
// Controller of the matrix multiply engine: configuration registers and the
// sequencer that walks k and q for a compute item. Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mme_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mme_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         row_index,
    input  logic [7:0]                         col_index,
    output mme_pkg::cmd_t                      cmd,
    input  mme_pkg::sts_t                      sts
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]                     rows_a_reg, rows_a_next;
    logic [mme_pkg::INNER_W-1:0]    inner_last_reg, inner_last_next;
    logic [mme_pkg::COL_W-1:0]      cols_last_reg, cols_last_next;

    logic [mme_pkg::ROW_W-1:0]      p_reg, p_next;
    logic [mme_pkg::INNER_W-1:0]    k_reg, k_next;
    logic [mme_pkg::COL_W-1:0]      q_reg, q_next;
    logic [mme_pkg::CREDIT_W-1:0]   credit_reg, credit_next;

    logic [4:0] rows_v;
    logic [8:0] inner_v, inner_c;
    logic [6:0] cols_v, cols_c;

    logic accept;
    logic start;
    logic can_issue;
    logic last_k;
    logic last_col;

    // Register writes clamp the low bits of cfg_data (5, 9 or 7 bits) to 1..maximum.
    always_comb
    begin
        rows_v  = cfg_data[4:0];
        inner_v = cfg_data[8:0];
        cols_v  = cfg_data[6:0];
        inner_c = (inner_v == 9'd0) ? 9'd1
                : (int'(inner_v) > mme_pkg::MAX_INNER) ? 9'(mme_pkg::MAX_INNER) : inner_v;
        cols_c  = (cols_v == 7'd0) ? 7'd1
                : (int'(cols_v) > mme_pkg::MAX_COLS) ? 7'(mme_pkg::MAX_COLS) : cols_v;
        rows_a_next     = rows_a_reg;
        inner_last_next = inner_last_reg;
        cols_last_next  = cols_last_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                mme_pkg::REG_ROWS_A:
                begin
                    rows_a_next = (rows_v == 5'd0) ? 5'd1
                        : (int'(rows_v) > mme_pkg::MAX_ROWS) ? 5'(mme_pkg::MAX_ROWS) : rows_v;
                end
                mme_pkg::REG_INNER_LEN:
                begin
                    inner_last_next = mme_pkg::INNER_W'(inner_c - 9'd1);
                end
                mme_pkg::REG_COLS_B:
                begin
                    cols_last_next = mme_pkg::COL_W'(cols_c - 7'd1);
                end
                default:
                begin
                    rows_a_next = rows_a_reg;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign start    = accept && (operation == mme_pkg::OP_COMPUTE)
                      && (int'(row_index) < int'(rows_a_reg));

    assign last_k    = (k_reg == inner_last_reg);
    assign last_col  = (q_reg == cols_last_reg);
    // A new column starts only when the result queue is sure to have room.
    assign can_issue = (k_reg != '0)
                       || (credit_reg < mme_pkg::CREDIT_W'(mme_pkg::FIFO_DEPTH));

    always_comb
    begin
        cmd.a_we = accept && (operation == mme_pkg::OP_LOAD_A)
                   && (int'(row_index) < mme_pkg::MAX_ROWS)
                   && (int'(col_index) < mme_pkg::MAX_INNER);
        cmd.b_we = accept && (operation == mme_pkg::OP_LOAD_B)
                   && (int'(row_index) < mme_pkg::MAX_INNER)
                   && (int'(col_index) < mme_pkg::MAX_COLS);
        cmd.rd_en        = (state_reg == ST_RUN) && can_issue;
        cmd.first        = (k_reg == '0);
        cmd.last_k       = last_k;
        cmd.k            = k_reg;
        cmd.tag.row      = p_reg;
        cmd.tag.col      = q_reg;
        cmd.tag.last_col = last_col;
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        q_next     = q_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    p_next     = mme_pkg::ROW_W'(row_index);
                    k_next     = '0;
                    q_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.rd_en)
                begin
                    if (last_k)
                    begin
                        k_next = '0;
                        q_next = q_reg + 1'b1;
                        if (last_col)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Credits count columns started whose result has not left the queue.
    always_comb
    begin
        credit_next = credit_reg;
        if ((cmd.rd_en && cmd.first) && !sts.pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!(cmd.rd_en && cmd.first) && sts.pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rows_a_reg     <= 5'(mme_pkg::MAX_ROWS);
            inner_last_reg <= mme_pkg::INNER_W'(mme_pkg::MAX_INNER - 1);
            cols_last_reg  <= mme_pkg::COL_W'(mme_pkg::MAX_COLS - 1);
            p_reg          <= '0;
            k_reg          <= '0;
            q_reg          <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rows_a_reg     <= rows_a_next;
            inner_last_reg <= inner_last_next;
            cols_last_reg  <= cols_last_next;
            p_reg          <= p_next;
            k_reg          <= k_next;
            q_reg          <= q_next;
            credit_reg     <= credit_next;
        end
    end

endmodule

[src/mme_datapath.sv]
// Datapath of the matrix multiply engine: A and B stores, the MAC pipeline,
// rounding and saturation, and the result queue. Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  mme_pkg::cmd_t       cmd,
    output mme_pkg::sts_t       sts,
    input  logic [7:0]          row_index,
    input  logic [7:0]          col_index,
    input  logic signed [15:0]  elem_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          out_row,
    output logic [5:0]          out_col,
    output logic signed [15:0]  out_value,
    output logic                saturated,
    output logic                last
);

    localparam int A_AW  = mme_pkg::ROW_W + mme_pkg::INNER_W;
    localparam int B_AW  = mme_pkg::INNER_W + mme_pkg::COL_W;
    localparam int Q_W   = mme_pkg::ACC_W - 7;

    logic signed [15:0] a_mem [2**A_AW];
    logic signed [15:0] b_mem [2**B_AW];

    logic [A_AW-1:0] a_waddr, a_raddr;
    logic [B_AW-1:0] b_waddr, b_raddr;

    // Stage 1: store read data.
    logic signed [15:0] a_rd_reg, b_rd_reg;
    logic               s1_vld_reg, s1_first_reg, s1_lastk_reg;
    mme_pkg::tag_t      s1_tag_reg;

    // Stage 2: product.
    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic                              s2_vld_reg, s2_first_reg, s2_lastk_reg;
    mme_pkg::tag_t                     s2_tag_reg;

    // Stage 3: accumulator.
    logic signed [mme_pkg::ACC_W-1:0] acc_reg;
    logic                             s3_done_reg;
    mme_pkg::tag_t                    s3_tag_reg;

    // Stage 4: sign and magnitude of the finished sum.
    logic [mme_pkg::ACC_W-1:0] mag_reg;
    logic                      neg_reg;
    logic                      s4_vld_reg;
    mme_pkg::tag_t             s4_tag_reg;

    // Rounding into the queue.
    logic [mme_pkg::ACC_W:0] rnd_sum;
    logic [Q_W-1:0]          q_mag;
    mme_pkg::result_t        res;

    // Result queue.
    mme_pkg::result_t             fifo_mem [mme_pkg::FIFO_DEPTH];
    logic [mme_pkg::FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [mme_pkg::CREDIT_W-1:0] count_reg, count_next;
    logic                         push, pop;
    mme_pkg::result_t             head;

    assign a_waddr = {mme_pkg::ROW_W'(row_index), mme_pkg::INNER_W'(col_index)};
    assign b_waddr = {mme_pkg::INNER_W'(row_index), mme_pkg::COL_W'(col_index)};
    assign a_raddr = {cmd.tag.row, cmd.k};
    assign b_raddr = {cmd.k, cmd.tag.col};

    always_ff @(posedge clk)
    begin
        if (cmd.a_we)
        begin
            a_mem[a_waddr] <= elem_value;
        end
        if (cmd.rd_en)
        begin
            a_rd_reg <= a_mem[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.b_we)
        begin
            b_mem[b_waddr] <= elem_value;
        end
        if (cmd.rd_en)
        begin
            b_rd_reg <= b_mem[b_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_done_reg <= 1'b0;
            s4_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= cmd.rd_en;
            s2_vld_reg  <= s1_vld_reg;
            s3_done_reg <= s2_vld_reg && s2_lastk_reg;
            s4_vld_reg  <= s3_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_lastk_reg <= cmd.last_k;
        s1_tag_reg   <= cmd.tag;

        prod_reg     <= a_rd_reg * b_rd_reg;
        s2_first_reg <= s1_first_reg;
        s2_lastk_reg <= s1_lastk_reg;
        s2_tag_reg   <= s1_tag_reg;

        if (s2_vld_reg)
        begin
            if (s2_first_reg)
            begin
                acc_reg <= mme_pkg::ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + mme_pkg::ACC_W'(prod_reg);
            end
        end
        s3_tag_reg <= s2_tag_reg;

        neg_reg    <= acc_reg[mme_pkg::ACC_W-1];
        mag_reg    <= acc_reg[mme_pkg::ACC_W-1] ? mme_pkg::ACC_W'(-acc_reg)
                                                : mme_pkg::ACC_W'(acc_reg);
        s4_tag_reg <= s3_tag_reg;
    end

    // Round to nearest with ties away from zero, then saturate to Q8.8.
    always_comb
    begin
        rnd_sum      = {1'b0, mag_reg} + (mme_pkg::ACC_W + 1)'(128);
        q_mag        = rnd_sum[mme_pkg::ACC_W:8];
        res.row      = 4'(s4_tag_reg.row);
        res.col      = 6'(s4_tag_reg.col);
        res.last     = s4_tag_reg.last_col;
        if (neg_reg)
        begin
            res.sat   = (q_mag > Q_W'(32768));
            res.value = res.sat ? 16'sh8000 : -signed'(16'(q_mag));
        end
        else
        begin
            res.sat   = (q_mag > Q_W'(32767));
            res.value = res.sat ? 16'sh7FFF : signed'(16'(q_mag));
        end
    end

    assign push      = s4_vld_reg;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign sts.pop   = pop;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head      = fifo_mem[rd_ptr_reg];
    assign out_row   = head.row;
    assign out_col   = head.col;
    assign out_value = head.value;
    assign saturated = head.sat;
    assign last      = head.last;

endmodule

[src/matrix_multiply_engine_top.sv]
// Top level of the matrix multiply engine, C = A times B in signed Q8.8.
// Instantiates mme_ctrl and mme_datapath; depends on mme_pkg.
`timescale 1ns / 1ps

// A load item (operation 0 for A, 1 for B) writes one Q8.8 element into an
// on-chip store; loads outside the store are dropped. A compute item
// (operation 2) for a row p below rows_a runs one multiply-accumulate per
// cycle through a single MAC unit, unless held back by the output queue:
// when eight columns have been started and not yet taken from the output
// queue, the next column waits until the receiver takes a result. The input
// stays busy until column cols_b-1 issues its last multiply-accumulate. A
// column's result passes the store read, product, accumulator and
// sign-magnitude registers into the output queue. Results leave in column
// order, with last set on column cols_b-1. The sum is exact in a 41-bit
// accumulator, then rounded to nearest (ties away from zero) and clamped to
// Q8.8 with the saturated flag. Rows of C at or above rows_a and operation
// code 3 are dropped without a result. The stores are not cleared by reset,
// so every element of A and B that a compute item reads must be loaded
// first. Configuration registers (0 rows_a, 1 inner_len, 2 cols_b) clamp
// the low 5, 9 and 7 bits of cfg_data to 1..maximum and may be written only
// while no item is in progress and all results have been taken.

module matrix_multiply_engine_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mme_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mme_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         row_index,
    input  logic [7:0]                         col_index,
    input  logic signed [15:0]                 elem_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3:0]                         out_row,
    output logic [5:0]                         out_col,
    output logic signed [15:0]                 out_value,
    output logic                               saturated,
    output logic                               last
);

    // Commands from the sequencer and queue status back to it.
    mme_pkg::cmd_t cmd;
    mme_pkg::sts_t sts;

    mme_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .row_index    (row_index),
        .col_index    (col_index),
        .cmd          (cmd),
        .sts          (sts)
    );

    mme_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .saturated  (saturated),
        .last       (last)
    );

endmodule
